FILE: src/gpr_pkg.sv
// Shared constants, types and the arctangent table for the grid point rotator.
// Depends on nothing; imported by gpr_cordic and grid_point_rotator_unit.
`default_nettype none

package gpr_pkg;

    // Grid geometry
    localparam int unsigned GRID_WIDTH  = 256;
    localparam int unsigned GRID_HEIGHT = 256;
    localparam int unsigned PLANE       = GRID_WIDTH * GRID_HEIGHT;

    // Field widths
    localparam int IDX_W    = 20;
    localparam int CTR_W    = 10;
    localparam int ANGLE_W  = 16;
    localparam int OUT_W    = 12;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 24;

    // Index split widths
    localparam int PLANE_W = $clog2(PLANE);
    localparam int COL_W   = $clog2(GRID_WIDTH);
    localparam int ROW_W   = $clog2(GRID_HEIGHT);

    // Reciprocal for index mod plane: floor(2^S/D), estimate low by at most one
    localparam int              P_SH    = IDX_W + $clog2(PLANE);
    localparam int              P_RCP_W = IDX_W + 1;
    localparam longint unsigned P_RCP   = (64'd1 << P_SH) / PLANE;
    localparam int              P_PROD_W = IDX_W + P_RCP_W;

    // Reciprocal for the in-plane offset div grid width
    localparam int              W_SH    = PLANE_W + $clog2(GRID_WIDTH);
    localparam int              W_RCP_W = PLANE_W + 1;
    localparam longint unsigned W_RCP   = (64'd1 << W_SH) / GRID_WIDTH;
    localparam int              W_PROD_W = PLANE_W + W_RCP_W;

    // Rotation arithmetic
    localparam int COEF_W = 18;
    localparam int REL_W  = CTR_W + 1;
    localparam int PROD_W = COEF_W + REL_W;
    localparam int SUM_W  = PROD_W + 1;

    // CORDIC
    localparam int CORDIC_STEPS = 22;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int XY_W         = 33;
    localparam int Z_W          = 25;
    localparam int ATAN_W       = 22;

    localparam logic [ATAN_W-1:0] ATAN_TBL [CORDIC_STEPS] = '{
        22'd2097152, 22'd1238021, 22'd654136, 22'd332050, 22'd166669, 22'd83416,
        22'd41718,   22'd20860,   22'd10430,  22'd5215,   22'd2608,   22'd1304,
        22'd652,     22'd326,     22'd163,    22'd81,     22'd41,     22'd20,
        22'd10,      22'd5,       22'd3,      22'd1
    };

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE = 2'd2;

    // Coefficient status from the CORDIC unit
    typedef struct packed {
        logic                     busy;
        logic signed [COEF_W-1:0] cos_q;
        logic signed [COEF_W-1:0] sin_q;
    } trig_t;

endpackage

`default_nettype wire

FILE: src/gpr_cordic.sv
// Iterative CORDIC: cosine and sine of the configured angle in Q1.16.
// Depends on gpr_pkg (table, widths, trig_t); one step per cycle.
`default_nettype none

module gpr_cordic (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [gpr_pkg::ANGLE_W-1:0] angle,
    output gpr_pkg::trig_t                   trig
);
    import gpr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } cordic_state_t;

    localparam logic signed [XY_W-1:0] GAIN_Q30 = 33'sd652032874;
    localparam logic signed [XY_W-1:0] RND_HALF = 33'sd8192;
    localparam logic signed [XY_W-1:0] CLAMP_HI = 33'sd65536;
    localparam logic signed [XY_W-1:0] CLAMP_LO = -33'sd65536;

    cordic_state_t state_reg, state_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic [1:0]             quad_reg, quad_next;
    logic signed [COEF_W-1:0] cos_reg, cos_next, sin_reg, sin_next;

    logic signed [XY_W-1:0] dx, dy, xr, yr;
    logic signed [Z_W-1:0]  ang_step;
    logic signed [COEF_W-1:0] cq, sq;

    always_comb begin
        dx       = y_reg >>> step_reg;
        dy       = x_reg >>> step_reg;
        ang_step = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_TBL[step_reg]});

        xr = (x_reg + RND_HALF) >>> 14;
        yr = (y_reg + RND_HALF) >>> 14;
        if (xr > CLAMP_HI)      cq = COEF_W'(CLAMP_HI);
        else if (xr < CLAMP_LO) cq = COEF_W'(CLAMP_LO);
        else                    cq = COEF_W'(xr);
        if (yr > CLAMP_HI)      sq = COEF_W'(CLAMP_HI);
        else if (yr < CLAMP_LO) sq = COEF_W'(CLAMP_LO);
        else                    sq = COEF_W'(yr);
    end

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        quad_next  = quad_reg;
        cos_next   = cos_reg;
        sin_next   = sin_reg;
        if (start) begin
            state_next = ST_RUN;
            step_next  = '0;
            x_next     = GAIN_Q30;
            y_next     = '0;
            z_next     = $signed({{(Z_W-14-8){1'b0}}, angle[13:0], 8'b0});
            quad_next  = angle[15:14];
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                end
                ST_RUN: begin
                    if (z_reg >= 0) begin
                        x_next = x_reg - dx;
                        y_next = y_reg + dy;
                        z_next = z_reg - ang_step;
                    end else begin
                        x_next = x_reg + dx;
                        y_next = y_reg - dy;
                        z_next = z_reg + ang_step;
                    end
                    if (step_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                        state_next = ST_FIN;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
                ST_FIN: begin
                    // fold the quarter turn back in exactly
                    unique case (quad_reg)
                        2'd0: begin cos_next = cq;  sin_next = sq;  end
                        2'd1: begin cos_next = -sq; sin_next = cq;  end
                        2'd2: begin cos_next = -cq; sin_next = -sq; end
                        2'd3: begin cos_next = sq;  sin_next = -cq; end
                    endcase
                    state_next = ST_IDLE;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        quad_reg <= quad_next;
        cos_reg  <= cos_next;
        sin_reg  <= sin_next;
    end

    assign trig.busy  = (state_reg != ST_IDLE);
    assign trig.cos_q = cos_reg;
    assign trig.sin_q = sin_reg;

endmodule

`default_nettype wire

FILE: src/grid_point_rotator_unit.sv
// Grid point rotator top level: index split, rotation pipeline, config port.
// Depends on gpr_pkg and gpr_cordic.
`default_nettype none

// Takes one linear cell index per beat on s_*, splits it into column and row
// (row taken within one plane), rotates the point counter-clockwise by
// turn_angle about (center_col, center_row) with the row axis pointing down,
// and returns the rounded, saturated coordinates on m_*. The datapath is a
// nine-stage pipeline with a valid bit per stage and per-stage enables, so it
// accepts one index every cycle while the output is ready and fills bubbles
// while the output is stalled. Cosine and sine come from an iterative CORDIC
// that runs after reset and after every write of turn_angle; s_tready stays
// low while it runs. Configuration writes are always taken (cfg_ready high);
// index 3 is ignored. Write the registers only while the pipeline is empty.
module grid_point_rotator_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [gpr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [gpr_pkg::CFG_DATA_W-1:0] cfg_data,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [gpr_pkg::S_DATA_W-1:0]   s_tdata,  // [19:0] cell_index
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [gpr_pkg::M_DATA_W-1:0]        m_tdata   // [11:0] rotated_col,
                                                          // [23:12] rotated_row
);
    import gpr_pkg::*;

    localparam int NSTG = 9;

    // configuration registers
    logic [CTR_W-1:0]   cc_reg, cr_reg;
    logic [ANGLE_W-1:0] angle_reg;
    logic               start_reg;
    logic               cfg_wr;
    logic               busy;

    trig_t trig;

    // pipeline control
    logic [NSTG-1:0] vld_reg, vld_next;
    logic [NSTG-1:0] en;

    // stage payloads
    logic [IDX_W-1:0]    idx1_reg, idx2_reg;
    logic [P_PROD_W-1:0] p1_reg;
    logic [IDX_W-1:0]    m1_reg;
    logic [PLANE_W-1:0]  rem3_reg, rem4_reg, rem5_reg;
    logic [W_PROD_W-1:0] p2_reg;
    logic [ROW_W-1:0]    q5_reg;
    logic [PLANE_W-1:0]  m2_reg;
    logic [COL_W-1:0]    col6_reg;
    logic [ROW_W-1:0]    row6_reg;
    logic signed [PROD_W-1:0] pcc_reg, psr_reg, psc_reg, pcr_reg;
    logic signed [SUM_W-1:0]  sumc_reg, sumr_reg;
    logic signed [OUT_W-1:0]  outc_reg, outr_reg;

    // stage next values
    logic [P_PROD_W-1:0] p1_next;
    logic [IDX_W-1:0]    q1, m1_next, r1;
    logic [PLANE_W-1:0]  rem3_next;
    logic [W_PROD_W-1:0] p2_next;
    logic [ROW_W-1:0]    q2;
    logic [PLANE_W-1:0]  m2_next, r2;
    logic [COL_W-1:0]    col6_next;
    logic [ROW_W-1:0]    row6_next;
    logic signed [REL_W-1:0]  rel_c, rel_r;
    logic signed [PROD_W-1:0] pcc_next, psr_next, psc_next, pcr_next;
    logic signed [SUM_W-1:0]  cc_q16, cr_q16, sumc_next, sumr_next;
    logic signed [OUT_W-1:0]  outc_next, outr_next;

    // Round half away from zero on Q16, then saturate to the output range.
    function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] rmag;
        logic             neg;
        neg  = v[SUM_W-1];
        mag  = neg ? SUM_W'(-v) : SUM_W'(v);
        rmag = (mag + SUM_W'(32768)) >> 16;
        if (!neg && rmag > SUM_W'(2047))      round_sat = OUT_W'(2047);
        else if (neg && rmag > SUM_W'(2048))  round_sat = OUT_W'(-2048);
        else if (neg)                         round_sat = OUT_W'(-$signed(rmag));
        else                                  round_sat = OUT_W'(rmag);
    endfunction

    // ---------------------------------------------------------------------
    // Configuration: always ready; restart the CORDIC on every angle write
    // ---------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg    <= '0;
            cr_reg    <= '0;
            angle_reg <= '0;
            start_reg <= 1'b1;
        end else begin
            start_reg <= cfg_wr && (cfg_index == CFG_TURN_ANGLE);
            if (cfg_wr) begin
                unique case (cfg_index)
                    CFG_CENTER_COL: cc_reg    <= cfg_data[CTR_W-1:0];
                    CFG_CENTER_ROW: cr_reg    <= cfg_data[CTR_W-1:0];
                    CFG_TURN_ANGLE: angle_reg <= cfg_data[ANGLE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    gpr_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start_reg),
        .angle   (angle_reg),
        .trig    (trig)
    );

    assign busy = start_reg || trig.busy;

    // ---------------------------------------------------------------------
    // Pipeline control: a stage advances when empty or when the next one does
    // ---------------------------------------------------------------------
    always_comb begin
        en[NSTG-1] = !vld_reg[NSTG-1] || m_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_tready = en[0] && !busy;

    always_comb begin
        vld_next = vld_reg;
        if (en[0]) vld_next[0] = s_tvalid && s_tready;
        for (int k = 1; k < NSTG; k++) begin
            if (en[k]) vld_next[k] = vld_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // ---------------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------------
    always_comb begin
        // stage 1: reciprocal product for index mod plane
        p1_next = P_PROD_W'(s_tdata[IDX_W-1:0]) * P_PROD_W'(P_RCP);

        // stage 2: quotient estimate times plane size
        q1      = IDX_W'(p1_reg >> P_SH);
        m1_next = IDX_W'(q1 * PLANE);

        // stage 3: remainder with one correction
        r1 = idx2_reg - m1_reg;
        if (r1 >= PLANE) rem3_next = PLANE_W'(r1 - PLANE);
        else             rem3_next = PLANE_W'(r1);

        // stage 4: reciprocal product for div grid width
        p2_next = W_PROD_W'(rem3_reg) * W_PROD_W'(W_RCP);

        // stage 5: row estimate times grid width
        q2      = ROW_W'(p2_reg >> W_SH);
        m2_next = PLANE_W'(q2 * GRID_WIDTH);

        // stage 6: column and row with one correction
        r2 = rem5_reg - m2_reg;
        if (r2 >= GRID_WIDTH) begin
            col6_next = COL_W'(r2 - GRID_WIDTH);
            row6_next = q5_reg + 1'b1;
        end else begin
            col6_next = COL_W'(r2);
            row6_next = q5_reg;
        end

        // stage 7: offsets from the centre and the four products
        rel_c    = $signed(REL_W'(col6_reg)) - $signed(REL_W'(cc_reg));
        rel_r    = $signed(REL_W'(cr_reg)) - $signed(REL_W'(row6_reg));
        pcc_next = PROD_W'(trig.cos_q) * PROD_W'(rel_c);
        psr_next = PROD_W'(trig.sin_q) * PROD_W'(rel_r);
        psc_next = PROD_W'(trig.sin_q) * PROD_W'(rel_c);
        pcr_next = PROD_W'(trig.cos_q) * PROD_W'(rel_r);

        // stage 8: add the centre in Q16
        cc_q16    = $signed(SUM_W'({cc_reg, 16'b0}));
        cr_q16    = $signed(SUM_W'({cr_reg, 16'b0}));
        sumc_next = cc_q16 + SUM_W'(pcc_reg) - SUM_W'(psr_reg);
        sumr_next = cr_q16 - (SUM_W'(psc_reg) + SUM_W'(pcr_reg));

        // stage 9: round and saturate into the output register
        outc_next = round_sat(sumc_reg);
        outr_next = round_sat(sumr_reg);
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            idx1_reg <= s_tdata[IDX_W-1:0];
            p1_reg   <= p1_next;
        end
        if (en[1]) begin
            idx2_reg <= idx1_reg;
            m1_reg   <= m1_next;
        end
        if (en[2]) rem3_reg <= rem3_next;
        if (en[3]) begin
            rem4_reg <= rem3_reg;
            p2_reg   <= p2_next;
        end
        if (en[4]) begin
            rem5_reg <= rem4_reg;
            q5_reg   <= q2;
            m2_reg   <= m2_next;
        end
        if (en[5]) begin
            col6_reg <= col6_next;
            row6_reg <= row6_next;
        end
        if (en[6]) begin
            pcc_reg <= pcc_next;
            psr_reg <= psr_next;
            psc_reg <= psc_next;
            pcr_reg <= pcr_next;
        end
        if (en[7]) begin
            sumc_reg <= sumc_next;
            sumr_reg <= sumr_next;
        end
        if (en[8]) begin
            outc_reg <= outc_next;
            outr_reg <= outr_next;
        end
    end

    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = {outr_reg, outc_reg};

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
`ifndef SYNTHESIS
    // hold off input while the coefficients are being recomputed
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_tready)
        else $error("input accepted while CORDIC busy");

    // an angle write must restart the coefficient unit
    a_angle_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_valid && cfg_ready && (cfg_index == CFG_TURN_ANGLE)) |=> busy)
        else $error("angle write did not restart CORDIC");

    // finished coefficients stay within plus and minus one
    a_coef_range: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy |-> ((trig.cos_q <= 18'sd65536) && (trig.cos_q >= -18'sd65536) &&
                   (trig.sin_q <= 18'sd65536) && (trig.sin_q >= -18'sd65536)))
        else $error("coefficient out of range");
`endif

endmodule

`default_nettype wire
